// ===== rtl/periodic_task_scheduler_defines.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef PERIODIC_TASK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/pts_pkg.sv =====
// Package with types, codes and helpers for the periodic task scheduler.
package pts_pkg;
  localparam int SLOTS = 8;
  localparam int SW = 3;
  localparam logic [16:0] CPMS_RESET = 17'd16000;
  localparam logic [15:0] UNENDING = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_DONE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_FIRED  = 3'd0,
    K_DROPS  = 3'd1,
    K_SUM    = 3'd2,
    K_ADDED  = 3'd3,
    K_BADPAR = 3'd4,
    K_FULL   = 3'd5,
    K_TERR   = 3'd6,
    K_ACK    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_EMPTY  = 2'd0,
    ST_NEW    = 2'd1,
    ST_READY  = 2'd2,
    ST_ACTIVE = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL, B_SLOT, B_DIV, B_SUM
  } bstate_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] executions;
    logic [31:0] period_ms;
    logic [31:0] delay_ms;
    logic [31:0] elapsed_cycles;
    logic [2:0]  done_slot;
    logic [7:0]  done_code;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [15:0] value;
    logic [31:0] next_deadline;
    logic        deadline_valid;
    logic        last;
  } out_t;

  // One queued command after classification in the front part.
  typedef struct packed {
    op_t         op;
    logic        bad;
    logic [15:0] runs;
    logic [31:0] period_ms;
    logic [31:0] delay_ms;
    logic [31:0] elapsed;
    logic [2:0]  slot;
    logic [7:0]  code;
  } cmd_t;

  // Saturate a 49-bit product to 32 bits.
  function automatic logic [31:0] sat32(input logic [48:0] p);
    sat32 = (|p[48:32]) ? 32'hFFFF_FFFF : p[31:0];
  endfunction
endpackage

// ===== rtl/pts_front.sv =====
// Front part: accepts commands, classifies them and queues them for the back part.
module pts_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  pts_pkg::in_t   in_data,
  output logic           busy,
  output logic           q_valid,
  output pts_pkg::cmd_t  q_data,
  input  logic           q_pop
);
  // Two-entry queue.
  pts_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       push;
  pts_pkg::cmd_t c;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy && (in_data.op != pts_pkg::OP_NONE);
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = q_r[rd_r];

  always_comb begin
    c.op        = pts_pkg::op_t'(in_data.op);
    c.bad       = (in_data.period_ms == 32'd0) && (in_data.executions != 16'd1);
    c.runs      = (in_data.executions == 16'd0) ? pts_pkg::UNENDING : in_data.executions;
    c.period_ms = in_data.period_ms;
    c.delay_ms  = in_data.delay_ms;
    c.elapsed   = in_data.elapsed_cycles;
    c.slot      = in_data.done_slot;
    c.code      = in_data.done_code;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= c;
    end
  end
endmodule

// ===== rtl/pts_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module pts_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);
  logic [31:0] q_r, q_nxt;
  logic [32:0] r_r, r_nxt;
  logic [5:0]  n_r, n_nxt;
  logic        act_r, act_nxt;
  logic [32:0] sh;
  logic [31:0] d_r;

  assign done = act_r && (n_r == 6'd0);
  assign quo  = q_r;
  assign rem  = r_r[31:0];

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    n_nxt = n_r;
    act_nxt = act_r;
    sh = {r_r[31:0], q_r[31]};
    if (go) begin
      q_nxt = num;
      r_nxt = 33'd0;
      n_nxt = 6'd32;
      act_nxt = 1'b1;
    end else if (act_r && n_r != 6'd0) begin
      if (sh >= {1'b0, d_r}) begin
        r_nxt = sh - {1'b0, d_r};
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        r_nxt = sh;
        q_nxt = {q_r[30:0], 1'b0};
      end
      n_nxt = n_r - 6'd1;
    end else if (done) begin
      act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      n_r   <= 6'd0;
    end else begin
      act_r <= act_nxt;
      n_r   <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (go) begin
      d_r <= den;
    end
  end
endmodule

// ===== rtl/pts_back.sv =====
// Back part: slot table, tick walk and result generation.
module pts_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [16:0]    cpms,
  input  logic           q_valid,
  input  pts_pkg::cmd_t  q_data,
  output logic           q_pop,
  output logic           res_vld,
  output pts_pkg::out_t  res
);
  pts_pkg::bstate_t st_r, st_nxt;
  pts_pkg::slot_st_t sst_r [pts_pkg::SLOTS];
  logic [15:0] runs_r [pts_pkg::SLOTS];
  logic [31:0] cd_r   [pts_pkg::SLOTS];
  logic [31:0] per_r  [pts_pkg::SLOTS];
  logic        newp_r;
  pts_pkg::cmd_t cmd_r;
  logic [2:0]  idx_r;
  logic        msel_r;       // product 0 delay, 1 period
  logic [31:0] dcyc_r;
  logic [15:0] fired_r;
  logic [31:0] best_r;
  logic        have_r;
  logic        dgo;
  logic        ddone;
  logic [31:0] dq, drm;
  logic [48:0] prod;
  logic [2:0]  free_idx;
  logic        free_any;
  pts_pkg::out_t o_nxt;
  logic        ov_nxt;

  // Slot-walk combinational values for slot idx_r.
  pts_pkg::slot_st_t cs;
  logic [31:0] ccd, cper, nper;
  logic [15:0] crun, nrun;
  logic        due, fire, keep, is_last_slot;
  logic [31:0] over;
  logic [31:0] ncd;
  pts_pkg::slot_st_t nst;
  logic        emit_drops_div;
  logic        live;

  pts_div u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .num(over), .den(per_r[idx_r]),
    .done(ddone), .quo(dq), .rem(drm)
  );

  assign prod = {17'd0, (msel_r ? cmd_r.period_ms : cmd_r.delay_ms)} * {32'd0, cpms};

  always_comb begin
    free_idx = 3'd0;
    free_any = 1'b0;
    for (int i = pts_pkg::SLOTS - 1; i >= 0; i--) begin
      if (sst_r[i] == pts_pkg::ST_EMPTY) begin
        free_idx = 3'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    cs   = sst_r[idx_r];
    if (newp_r && cs == pts_pkg::ST_NEW) begin
      cs = pts_pkg::ST_READY;
    end
    ccd  = cd_r[idx_r];
    cper = per_r[idx_r];
    crun = runs_r[idx_r];
    due  = (ccd <= cmd_r.elapsed);
    over = cmd_r.elapsed - ccd;
    fire = 1'b0;
    nrun = crun;
    ncd  = ccd;
    nper = cper;
    nst  = cs;
    emit_drops_div = 1'b0;
    if (cs == pts_pkg::ST_ACTIVE) begin
      if (!due) begin
        ncd = ccd - cmd_r.elapsed;
      end else begin
        fire = 1'b1;
      end
    end else if (cs == pts_pkg::ST_READY) begin
      nst = pts_pkg::ST_ACTIVE;
      if (ccd == 32'd0) begin
        fire = 1'b1;
        ncd = cper;
      end
    end
    if (fire && crun != pts_pkg::UNENDING) begin
      nrun = crun - 16'd1;
    end
    keep = (nrun != 16'd0);
    if (fire && keep && cs == pts_pkg::ST_ACTIVE) begin
      if (cper > over) begin
        ncd = cper - over;
      end else if (cper == 32'd0) begin
        ncd = 32'd0;
      end else begin
        emit_drops_div = 1'b1;
      end
    end
    if (fire && !keep) begin
      nst = pts_pkg::ST_EMPTY;
      nrun = 16'd0;
      ncd = 32'd0;
      nper = 32'd0;
    end
    live = (cs == pts_pkg::ST_ACTIVE || cs == pts_pkg::ST_READY)
        && (nst != pts_pkg::ST_EMPTY);
    is_last_slot = (idx_r == 3'(pts_pkg::SLOTS - 1));
  end

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    dgo = 1'b0;
    o_nxt = '0;
    ov_nxt = 1'b0;
    unique case (st_r)
      pts_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_data.op)
            pts_pkg::OP_ADD: begin
              if (q_data.bad) begin
                ov_nxt = 1'b1;
                o_nxt.kind = pts_pkg::K_BADPAR;
                o_nxt.last = 1'b1;
              end else begin
                st_nxt = pts_pkg::B_MUL;
              end
            end
            pts_pkg::OP_TICK: st_nxt = pts_pkg::B_SLOT;
            default: begin
              ov_nxt = 1'b1;
              o_nxt.slot = q_data.slot;
              o_nxt.last = 1'b1;
              if (q_data.code >= 8'd2) begin
                o_nxt.kind = pts_pkg::K_TERR;
                o_nxt.value = {8'd0, q_data.code};
              end else begin
                o_nxt.kind = pts_pkg::K_ACK;
              end
            end
          endcase
        end
      end
      pts_pkg::B_MUL: begin
        if (msel_r) begin
          st_nxt = pts_pkg::B_IDLE;
          ov_nxt = 1'b1;
          o_nxt.last = 1'b1;
          if (free_any) begin
            o_nxt.kind = pts_pkg::K_ADDED;
            o_nxt.slot = free_idx;
          end else begin
            o_nxt.kind = pts_pkg::K_FULL;
          end
        end
      end
      pts_pkg::B_SLOT: begin
        if (fire) begin
          ov_nxt = 1'b1;
          o_nxt.kind = pts_pkg::K_FIRED;
          o_nxt.slot = idx_r;
        end
        if (emit_drops_div) begin
          st_nxt = pts_pkg::B_DIV;
          dgo = 1'b1;
        end else if (is_last_slot) begin
          st_nxt = pts_pkg::B_SUM;
        end
      end
      pts_pkg::B_DIV: begin
        if (ddone) begin
          ov_nxt = 1'b1;
          o_nxt.kind = pts_pkg::K_DROPS;
          o_nxt.slot = idx_r;
          o_nxt.value = (|dq[31:16]) ? 16'hFFFF : dq[15:0];
          st_nxt = is_last_slot ? pts_pkg::B_SUM : pts_pkg::B_SLOT;
        end
      end
      pts_pkg::B_SUM: begin
        st_nxt = pts_pkg::B_IDLE;
        ov_nxt = 1'b1;
        o_nxt.kind = pts_pkg::K_SUM;
        o_nxt.value = fired_r;
        o_nxt.next_deadline = have_r ? best_r : 32'd0;
        o_nxt.deadline_valid = have_r;
        o_nxt.last = 1'b1;
      end
      default: st_nxt = pts_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= pts_pkg::B_IDLE;
      newp_r  <= 1'b0;
      res_vld <= 1'b0;
      msel_r  <= 1'b0;
      idx_r   <= 3'd0;
      fired_r <= 16'd0;
      have_r  <= 1'b0;
      for (int i = 0; i < pts_pkg::SLOTS; i++) begin
        sst_r[i] <= pts_pkg::ST_EMPTY;
      end
    end else begin
      st_r    <= st_nxt;
      res_vld <= ov_nxt;
      if (st_r == pts_pkg::B_IDLE && q_valid) begin
        msel_r  <= 1'b0;
        idx_r   <= 3'd0;
        fired_r <= 16'd0;
        have_r  <= 1'b0;
      end
      if (st_r == pts_pkg::B_MUL) begin
        msel_r <= 1'b1;
        if (msel_r && free_any) begin
          sst_r[free_idx] <= pts_pkg::ST_NEW;
          newp_r <= 1'b1;
        end
      end
      if (st_r == pts_pkg::B_IDLE && q_valid && q_data.op == pts_pkg::OP_DONE
          && q_data.code != 8'd0) begin
        sst_r[q_data.slot] <= pts_pkg::ST_EMPTY;
      end
      if (st_r == pts_pkg::B_SLOT) begin
        sst_r[idx_r] <= nst;
        if (fire) begin
          fired_r <= fired_r + 16'd1;
        end
        if (live && !emit_drops_div && (!have_r || ncd < best_r)) begin
          have_r <= 1'b1;
        end
        if (!emit_drops_div) begin
          idx_r <= idx_r + 3'd1;
        end
        if (is_last_slot && !emit_drops_div) begin
          newp_r <= 1'b0;
        end
      end
      if (st_r == pts_pkg::B_DIV && ddone) begin
        have_r <= 1'b1;
        idx_r  <= idx_r + 3'd1;
        if (is_last_slot) begin
          newp_r <= 1'b0;
        end
      end
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    res <= o_nxt;
    if (st_r == pts_pkg::B_IDLE && q_valid) begin
      cmd_r <= q_data;
      if (q_data.op == pts_pkg::OP_DONE && q_data.code != 8'd0) begin
        runs_r[q_data.slot] <= 16'd0;
        cd_r[q_data.slot]   <= 32'd0;
        per_r[q_data.slot]  <= 32'd0;
      end
    end
    if (st_r == pts_pkg::B_MUL) begin
      if (!msel_r) begin
        dcyc_r <= pts_pkg::sat32(prod);
      end else if (free_any) begin
        cd_r[free_idx]   <= dcyc_r;
        per_r[free_idx]  <= pts_pkg::sat32(prod);
        runs_r[free_idx] <= cmd_r.runs;
      end
    end
    if (st_r == pts_pkg::B_SLOT) begin
      runs_r[idx_r] <= nrun;
      per_r[idx_r]  <= nper;
      if (!emit_drops_div) begin
        cd_r[idx_r] <= ncd;
        if (live && (!have_r || ncd < best_r)) begin
          best_r <= ncd;
        end
      end
    end
    if (st_r == pts_pkg::B_DIV && ddone) begin
      cd_r[idx_r] <= cper - drm;
      if (!have_r || (cper - drm) < best_r) begin
        best_r <= cper - drm;
      end
    end
  end
endmodule

// ===== rtl/periodic_task_scheduler.sv =====
// Periodic task scheduler: the back part answers a completion or a bad add from
// its idle state, takes a good add through the multiplier for delay, then period,
// and walks a tick over every slot before it ends it with a summary; each overdue
// slot that must realign goes through the serial divider.
// A two-entry queue lets commands be taken while the back part works.
// Synchronous active-low reset empties all slots and sets cycles_per_ms to 16000.
`include "periodic_task_scheduler_defines.svh"
module periodic_task_scheduler (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  pts_pkg::in_t  in_data,
  output logic          out_valid,
  output pts_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [16:0]   cfg_data
);
  logic [16:0] cpms_r;
  logic        q_valid, q_pop;
  pts_pkg::cmd_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpms_r <= pts_pkg::CPMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cpms_r <= cfg_data;
    end
  end

  pts_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .busy(busy),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  pts_back u_back (
    .clk(clk), .rst_n(rst_n), .cpms(cpms_r), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .res_vld(out_valid), .res(out_data)
  );

  `PTS_ASSERT_IMP(a_pop_valid, q_pop, q_valid)
  `PTS_ASSERT_IMP(a_sum_last, out_valid && out_data.kind == pts_pkg::K_SUM, out_data.last)
  `PTS_ASSERT_NXT(a_busy_full, busy && !q_pop, busy)
endmodule
